[hw/rtl/cppm_frame_generator_defines.svh]
// ----------------------------------------------------------------------------
// CPPM frame generator assertion macros
// Shared property forms for the checker of the frame generator.
// ----------------------------------------------------------------------------
`ifndef CPPM_FRAME_GENERATOR_DEFINES_SVH
`define CPPM_FRAME_GENERATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define CPPM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CPPM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/cppm_pkg.sv]
// ----------------------------------------------------------------------------
// CPPM frame generator package
// Widths, reset values, register codes and structs shared by the modules.
// ----------------------------------------------------------------------------
`default_nettype none

package cppm_pkg;

   localparam int MAX_CHANNELS = 16;
   localparam int CH_IDX_W     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int SLOT_W       = $clog2(MAX_CHANNELS + 1);

   localparam int OPCODE_W      = 1;
   localparam int REQ_INDEX_W   = 4;
   localparam int CH_VALUE_W    = 12;
   localparam int SLOT_NUM_W    = 5;
   localparam int CH_COUNT_W    = 5;
   localparam int FRAME_LEN_W   = 16;
   localparam int PULSE_LEN_W   = 12;
   localparam int REMAIN_W      = 16;
   localparam int ELAPSED_W     = 17;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 16;

   localparam logic [CH_COUNT_W-1:0]  RESET_CH_COUNT   = CH_COUNT_W'(12);
   localparam logic [FRAME_LEN_W-1:0] RESET_FRAME_LEN  = FRAME_LEN_W'(22500);
   localparam logic [PULSE_LEN_W-1:0] RESET_PULSE_LEN  = PULSE_LEN_W'(300);
   localparam logic                   RESET_POLARITY   = 1'b1;
   localparam logic [CH_VALUE_W-1:0]  RESET_CH_VALUE   = CH_VALUE_W'(1500);
   localparam logic [REMAIN_W-1:0]    RESET_REMAINING  = REMAIN_W'(50);

   typedef enum logic [OPCODE_W-1:0] {
      OP_TICK  = 1'b0,
      OP_WRITE = 1'b1
   } opcode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CHANNEL_COUNT = 2'd0,
      CSR_FRAME_PERIOD  = 2'd1,
      CSR_SEP_WIDTH     = 2'd2,
      CSR_POLARITY      = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [CH_COUNT_W-1:0]  channel_count;
      logic [FRAME_LEN_W-1:0] frame_period;
      logic [PULSE_LEN_W-1:0] sep_width;
      logic                   polarity;
   } cfg_type;

   typedef struct packed {
      logic                  enable;
      logic [CH_IDX_W-1:0]   index;
      logic [CH_VALUE_W-1:0] value;
   } store_write_type;

   typedef struct packed {
      logic                  pin_level;
      logic                  frame_start;
      logic [SLOT_NUM_W-1:0] slot_number;
   } rsp_item_type;

endpackage

`default_nettype wire

[hw/rtl/cppm_frame_generator.sv]
// ----------------------------------------------------------------------------
// CPPM frame generator
// Builds a combined PPM frame from one microsecond ticks and channel writes.
//
//   Channel   Direction  Handshake           Payload
//   req_      in         req_valid/ready     opcode, channel_index, value
//   rsp_      out        rsp_valid/ready     pin_level, frame_start, slot
//   csr_      in         csr_write_enable    csr_index, csr_write_data
//
// For each accepted request the slot timer steps on a tick and the
// response enters a two-entry output queue at the same clock edge.
// A response is offered once it reaches the head of the output queue.
// Requests are accepted while the output queue has room, so one waiting
// response does not stall the input side.
// Reset is synchronous and restores the registers and all channels to defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module cppm_frame_generator (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [cppm_pkg::OPCODE_W-1:0]      req_opcode,
   input  wire logic [cppm_pkg::REQ_INDEX_W-1:0]   req_channel_index,
   input  wire logic [cppm_pkg::CH_VALUE_W-1:0]    req_channel_value,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic                                    rsp_pin_level,
   output logic                                    rsp_frame_start,
   output logic      [cppm_pkg::SLOT_NUM_W-1:0]    rsp_slot_number,
   input  wire logic                               csr_write_enable,
   input  wire logic [cppm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [cppm_pkg::CSR_DATA_W-1:0]    csr_write_data
);
   import cppm_pkg::*;

   cfg_type         cfg_ff;
   logic            accept;
   logic            tick;
   store_write_type store_wr;
   logic [CH_IDX_W-1:0]   ch_index;
   logic [CH_VALUE_W-1:0] ch_value;
   rsp_item_type    timer_result;
   rsp_item_type    push_item;
   rsp_item_type    out_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.channel_count <= RESET_CH_COUNT;
         cfg_ff.frame_period  <= RESET_FRAME_LEN;
         cfg_ff.sep_width     <= RESET_PULSE_LEN;
         cfg_ff.polarity      <= RESET_POLARITY;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_CHANNEL_COUNT: begin
               cfg_ff.channel_count <= csr_write_data[CH_COUNT_W-1:0];
            end
            CSR_FRAME_PERIOD: begin
               cfg_ff.frame_period <= csr_write_data[FRAME_LEN_W-1:0];
            end
            CSR_SEP_WIDTH: begin
               cfg_ff.sep_width <= csr_write_data[PULSE_LEN_W-1:0];
            end
            CSR_POLARITY: begin
               cfg_ff.polarity <= csr_write_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   assign accept = req_valid && req_ready;
   assign tick   = accept && (opcode_type'(req_opcode) == OP_TICK);

   assign store_wr.enable = accept && (opcode_type'(req_opcode) == OP_WRITE) &&
                            (32'(req_channel_index) < MAX_CHANNELS);
   assign store_wr.index  = CH_IDX_W'(req_channel_index);
   assign store_wr.value  = req_channel_value;

   cppm_chan_store u_chan_store (
      .clock    (clock),
      .reset    (reset),
      .wr       (store_wr),
      .rd_index (ch_index),
      .rd_value (ch_value)
   );

   cppm_slot_timer u_slot_timer (
      .clock    (clock),
      .reset    (reset),
      .tick     (tick),
      .cfg      (cfg_ff),
      .ch_value (ch_value),
      .ch_index (ch_index),
      .result   (timer_result)
   );

   always_comb begin
      push_item             = timer_result;
      push_item.frame_start = timer_result.frame_start && tick;
   end

   cppm_rsp_buffer u_rsp_buffer (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_item (push_item),
      .has_room  (req_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_item  (out_item)
   );

   assign rsp_pin_level   = out_item.pin_level;
   assign rsp_frame_start = out_item.frame_start;
   assign rsp_slot_number = out_item.slot_number;

endmodule

`default_nettype wire

[hw/rtl/cppm_chan_store.sv]
// ----------------------------------------------------------------------------
// CPPM channel store
// Holds the width of every channel, written by requests and read by slot.
// ----------------------------------------------------------------------------
`default_nettype none

module cppm_chan_store (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire cppm_pkg::store_write_type        wr,
   input  wire logic [cppm_pkg::CH_IDX_W-1:0]    rd_index,
   output logic      [cppm_pkg::CH_VALUE_W-1:0]  rd_value
);
   import cppm_pkg::*;

   logic [CH_VALUE_W-1:0] store_ff [MAX_CHANNELS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_CHANNELS; i++) begin
            store_ff[i] <= RESET_CH_VALUE;
         end
      end else if (wr.enable) begin
         store_ff[wr.index] <= wr.value;
      end
   end

   assign rd_value = store_ff[rd_index];

endmodule

`default_nettype wire

[hw/rtl/cppm_slot_timer.sv]
// ----------------------------------------------------------------------------
// CPPM slot timer
// Counts down to each pulse and gap edge and walks the slots of a frame.
// ----------------------------------------------------------------------------
`default_nettype none

module cppm_slot_timer (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             tick,
   input  wire cppm_pkg::cfg_type                cfg,
   input  wire logic [cppm_pkg::CH_VALUE_W-1:0]  ch_value,
   output logic      [cppm_pkg::CH_IDX_W-1:0]    ch_index,
   output cppm_pkg::rsp_item_type                result
);
   import cppm_pkg::*;

   logic [REMAIN_W-1:0]  remaining_ff, remaining_in;
   logic                 pulse_next_ff, pulse_next_in;
   logic [SLOT_W-1:0]    slot_ff, slot_in;
   logic [ELAPSED_W-1:0] elapsed_ff, elapsed_in;
   logic                 level_ff, level_in;
   logic                 start;
   logic [SLOT_W-1:0]    active_slots;
   logic [ELAPSED_W:0]   used;
   logic [REMAIN_W-1:0]  gap;

   assign active_slots = (32'(cfg.channel_count) < MAX_CHANNELS) ?
                         SLOT_W'(cfg.channel_count) : SLOT_W'(MAX_CHANNELS);
   assign ch_index = slot_ff[CH_IDX_W-1:0];
   assign used = {1'b0, elapsed_ff} + (ELAPSED_W+1)'(cfg.sep_width);

   always_comb begin
      remaining_in  = remaining_ff;
      pulse_next_in = pulse_next_ff;
      slot_in       = slot_ff;
      elapsed_in    = elapsed_ff;
      level_in      = level_ff;
      start         = 1'b0;
      gap           = '0;
      if (tick) begin
         if (remaining_ff <= REMAIN_W'(1)) begin
            if (pulse_next_ff) begin
               level_in      = cfg.polarity;
               remaining_in  = (cfg.sep_width == '0) ?
                               REMAIN_W'(1) : REMAIN_W'(cfg.sep_width);
               pulse_next_in = 1'b0;
               start         = (slot_ff == '0);
            end else begin
               level_in      = ~cfg.polarity;
               pulse_next_in = 1'b1;
               if (slot_ff >= active_slots) begin
                  gap        = ((ELAPSED_W+1)'(cfg.frame_period) > used) ?
                               REMAIN_W'((ELAPSED_W+1)'(cfg.frame_period) - used) :
                               REMAIN_W'(1);
                  slot_in    = '0;
                  elapsed_in = '0;
               end else begin
                  gap        = (ch_value > cfg.sep_width) ?
                               REMAIN_W'(ch_value - cfg.sep_width) :
                               REMAIN_W'(1);
                  elapsed_in = elapsed_ff + ELAPSED_W'(ch_value);
                  slot_in    = slot_ff + SLOT_W'(1);
               end
               remaining_in  = gap;
            end
         end else begin
            remaining_in = remaining_ff - REMAIN_W'(1);
         end
      end
   end

   always_comb begin
      result.pin_level   = level_in;
      result.frame_start = start;
      if (!pulse_next_in) begin
         result.slot_number = SLOT_NUM_W'(slot_in);
      end else if (slot_in == '0) begin
         result.slot_number = SLOT_NUM_W'(cfg.channel_count);
      end else begin
         result.slot_number = SLOT_NUM_W'(slot_in - SLOT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remaining_ff  <= RESET_REMAINING;
         pulse_next_ff <= 1'b1;
         slot_ff       <= '0;
         elapsed_ff    <= '0;
         level_ff      <= ~RESET_POLARITY;
      end else begin
         remaining_ff  <= remaining_in;
         pulse_next_ff <= pulse_next_in;
         slot_ff       <= slot_in;
         elapsed_ff    <= elapsed_in;
         level_ff      <= level_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/cppm_rsp_buffer.sv]
// ----------------------------------------------------------------------------
// CPPM response buffer
// Two-entry output queue that lets requests flow while a response waits.
// ----------------------------------------------------------------------------
`default_nettype none

module cppm_rsp_buffer (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire cppm_pkg::rsp_item_type  push_item,
   output logic                         has_room,
   output logic                         out_valid,
   input  wire logic                    out_ready,
   output cppm_pkg::rsp_item_type       out_item
);
   import cppm_pkg::*;

   rsp_item_type entry0_ff, entry1_ff;
   logic [1:0]   count_ff, count_in;
   logic         pop;

   assign pop       = out_valid && out_ready;
   assign has_room  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_item  = entry0_ff;
   assign count_in  = count_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         if (count_ff == 2'd2) begin
            entry0_ff <= entry1_ff;
         end else if (push) begin
            entry0_ff <= push_item;
         end
      end else if (push) begin
         if (count_ff == 2'd0) begin
            entry0_ff <= push_item;
         end else begin
            entry1_ff <= push_item;
         end
      end
   end

endmodule

`default_nettype wire

[hw/rtl/cppm_checker.sv]
// ----------------------------------------------------------------------------
// CPPM frame generator checker
// Port-level properties of the frame generator, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cppm_frame_generator_defines.svh"

module cppm_checker (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   input  wire logic                               req_ready,
   input  wire logic                               rsp_valid,
   input  wire logic                               rsp_ready,
   input  wire logic                               rsp_pin_level,
   input  wire logic                               rsp_frame_start,
   input  wire logic [cppm_pkg::SLOT_NUM_W-1:0]    rsp_slot_number
);
   import cppm_pkg::*;

   `CPPM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_pin_level) && $stable(rsp_frame_start) &&
      $stable(rsp_slot_number), "Stalled response changed or dropped.")

   `CPPM_ASSERT_NOW(a_start_slot_zero, clock, reset, rsp_valid && rsp_frame_start,
      rsp_slot_number == '0, "Frame start reported outside slot zero.")

   `CPPM_ASSERT_NOW(a_ready_when_empty, clock, reset, !rsp_valid,
      req_ready, "Request refused while no response is pending.")

   `CPPM_ASSERT_NEXT(a_rsp_follows_req, clock, reset,
      req_valid && req_ready && !rsp_valid,
      rsp_valid, "Accepted request produced no response in the next cycle.")

endmodule

bind cppm_frame_generator cppm_checker u_cppm_checker (.*);

`default_nettype wire
